### sv/nte_pkg.sv
// Shared types, field widths and codes for the neighbour table with expiry.
package nte_pkg;

	localparam int ENTRIES_DEF   = 4;
	localparam int NODE_W        = 8;
	localparam int TIME_W        = 32;
	localparam int POS_W         = 20;
	localparam int VEL_W         = 16;
	localparam int SEQ_W         = 16;
	localparam int PAYLOAD_W     = 3 * POS_W + 3 * VEL_W + SEQ_W;
	localparam int ENTRY_W       = NODE_W + TIME_W + PAYLOAD_W;
	localparam int MASK_W        = 4;
	localparam int SLOT_W        = 2;
	localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd3000;

	typedef enum logic {
		CMD_UPDATE = 1'b0,
		CMD_EXPIRE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		ACT_UPDATED  = 2'd0,
		ACT_INSERTED = 2'd1,
		ACT_REPLACED = 2'd2,
		ACT_EXPIRED  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FIN
	} state_t;

	typedef struct packed {
		logic load;
		logic issue;
		logic commit;
	} ctl_cmd_t;

	typedef struct packed {
		logic last_issue;
	} dp_status_t;

endpackage

### sv/nte_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module nte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### sv/nte_ctrl.sv
// Controller state machine: sequences load, slot scan, drain and commit of one beat.
module nte_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  nte_pkg::dp_status_t status,
	output nte_pkg::ctl_cmd_t   ctl
);

	nte_pkg::state_t state_q, state_d;
	logic out_valid_q;
	logic out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= nte_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.commit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		ctl.load   = 1'b0;
		ctl.issue  = 1'b0;
		ctl.commit = 1'b0;
		in_stall   = 1'b1;
		case (state_q)
			nte_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = nte_pkg::ST_SCAN;
				end
			end
			nte_pkg::ST_SCAN: begin
				ctl.issue = 1'b1;
				if (status.last_issue) begin
					state_d = nte_pkg::ST_DRAIN;
				end
			end
			nte_pkg::ST_DRAIN: begin
				// The last slot read is evaluated in this cycle.
				state_d = nte_pkg::ST_FIN;
			end
			nte_pkg::ST_FIN: begin
				if (out_free) begin
					ctl.commit = 1'b1;
					state_d    = nte_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = nte_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### sv/nte_datapath.sv
// Datapath: table storage, one-slot-per-cycle scan, target choice and result registers.
module nte_datapath #(
	parameter int ENTRIES = nte_pkg::ENTRIES_DEF,
	localparam int IW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  nte_pkg::ctl_cmd_t                  ctl,
	output nte_pkg::dp_status_t                status,
	input  logic                               cfg_we,
	input  logic [nte_pkg::TIME_W-1:0]         cfg_wdata,
	input  logic                               cmd,
	input  logic [nte_pkg::NODE_W-1:0]         node,
	input  logic [nte_pkg::POS_W-1:0]          pos_x,
	input  logic [nte_pkg::POS_W-1:0]          pos_y,
	input  logic [nte_pkg::POS_W-1:0]          pos_z,
	input  logic signed [nte_pkg::VEL_W-1:0]   vel_x,
	input  logic signed [nte_pkg::VEL_W-1:0]   vel_y,
	input  logic signed [nte_pkg::VEL_W-1:0]   vel_z,
	input  logic [nte_pkg::SEQ_W-1:0]          sequence_req,
	input  logic [nte_pkg::TIME_W-1:0]         now,
	output logic [1:0]                         action,
	output logic [nte_pkg::SLOT_W-1:0]         slot,
	output logic [nte_pkg::NODE_W-1:0]         evicted_node,
	output logic [nte_pkg::MASK_W-1:0]         expired_mask
);

	localparam int NW = nte_pkg::NODE_W;
	localparam int TW = nte_pkg::TIME_W;

	// Captured beat
	logic                         cmd_q;
	logic [NW-1:0]                node_q;
	logic [nte_pkg::PAYLOAD_W-1:0] payload_q;
	logic [TW-1:0]                now_q;

	logic [TW-1:0]      timeout_q;
	logic [ENTRIES-1:0] valid_q;

	// Scan read side and evaluation stage
	logic [IW-1:0] rd_idx_q;
	logic          issue_s1;
	logic [IW-1:0] idx_s1;

	// Search trackers
	logic          match_found_q, free_found_q, oldest_found_q;
	logic [IW-1:0] match_idx_q, free_idx_q, oldest_idx_q;
	logic [TW-1:0] oldest_time_q;
	logic [NW-1:0] oldest_node_q;
	logic [nte_pkg::MASK_W-1:0] mask_q;

	// Result registers
	logic [1:0]                 action_q;
	logic [nte_pkg::SLOT_W-1:0] slot_q;
	logic [NW-1:0]              evicted_q;
	logic [nte_pkg::MASK_W-1:0] expired_q;

	logic [nte_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;
	logic [NW-1:0]               rd_node;
	logic [TW-1:0]               rd_heard;
	logic [TW-1:0]               age;
	logic                        expire_hit;
	logic [IW-1:0]               target;
	logic [1:0]                  upd_action;
	logic                        write_en;

	assign rd_node    = ram_rdata[NW-1:0];
	assign rd_heard   = ram_rdata[NW+TW-1:NW];
	assign age        = now_q - rd_heard;
	assign expire_hit = valid_q[idx_s1] && (age > timeout_q);

	assign status.last_issue = (rd_idx_q == IW'(ENTRIES - 1));

	always_comb begin
		if (match_found_q) begin
			target     = match_idx_q;
			upd_action = nte_pkg::ACT_UPDATED;
		end else if (free_found_q) begin
			target     = free_idx_q;
			upd_action = nte_pkg::ACT_INSERTED;
		end else begin
			target     = oldest_idx_q;
			upd_action = nte_pkg::ACT_REPLACED;
		end
	end

	assign write_en  = ctl.commit && (cmd_q == nte_pkg::CMD_UPDATE);
	assign ram_wdata = {payload_q, now_q, node_q};

	nte_ram #(
		.WIDTH (nte_pkg::ENTRY_W),
		.DEPTH (ENTRIES)
	) u_table (
		.clk   (clk),
		.we    (write_en),
		.waddr (target),
		.wdata (ram_wdata),
		.raddr (rd_idx_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q      <= nte_pkg::TIMEOUT_RESET;
			valid_q        <= '0;
			rd_idx_q       <= '0;
			issue_s1       <= 1'b0;
			match_found_q  <= 1'b0;
			free_found_q   <= 1'b0;
			oldest_found_q <= 1'b0;
			mask_q         <= '0;
		end else begin
			if (cfg_we) begin
				timeout_q <= cfg_wdata;
			end
			issue_s1 <= ctl.issue;
			if (ctl.load) begin
				rd_idx_q       <= '0;
				match_found_q  <= 1'b0;
				free_found_q   <= 1'b0;
				oldest_found_q <= 1'b0;
				mask_q         <= '0;
			end else if (ctl.issue) begin
				rd_idx_q <= rd_idx_q + IW'(1);
			end
			if (issue_s1) begin
				if (cmd_q == nte_pkg::CMD_EXPIRE) begin
					if (expire_hit) begin
						valid_q[idx_s1] <= 1'b0;
						if (32'(idx_s1) < nte_pkg::MASK_W) begin
							mask_q[2'(idx_s1)] <= 1'b1;
						end
					end
				end else if (valid_q[idx_s1]) begin
					if (!match_found_q && rd_node == node_q) begin
						match_found_q <= 1'b1;
					end
					if (!oldest_found_q || rd_heard < oldest_time_q) begin
						oldest_found_q <= 1'b1;
					end
				end else if (!free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
			if (write_en) begin
				valid_q[target] <= 1'b1;
			end
		end
	end

	// Payload side of the trackers and the captured beat carry no reset.
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (ctl.load) begin
			cmd_q     <= cmd;
			node_q    <= node;
			now_q     <= now;
			payload_q <= {sequence_req, vel_z, vel_y, vel_x, pos_z, pos_y, pos_x};
		end
		if (issue_s1 && cmd_q == nte_pkg::CMD_UPDATE) begin
			if (valid_q[idx_s1]) begin
				if (!match_found_q && rd_node == node_q) begin
					match_idx_q <= idx_s1;
				end
				if (!oldest_found_q || rd_heard < oldest_time_q) begin
					oldest_idx_q  <= idx_s1;
					oldest_time_q <= rd_heard;
					oldest_node_q <= rd_node;
				end
			end else if (!free_found_q) begin
				free_idx_q <= idx_s1;
			end
		end
		if (ctl.commit) begin
			if (cmd_q == nte_pkg::CMD_EXPIRE) begin
				action_q  <= nte_pkg::ACT_EXPIRED;
				slot_q    <= '0;
				evicted_q <= '0;
				expired_q <= mask_q;
			end else begin
				action_q  <= upd_action;
				slot_q    <= nte_pkg::SLOT_W'(target);
				evicted_q <= (upd_action == nte_pkg::ACT_REPLACED) ? oldest_node_q : '0;
				expired_q <= '0;
			end
		end
	end

	assign action       = action_q;
	assign slot         = slot_q;
	assign evicted_node = evicted_q;
	assign expired_mask = expired_q;

endmodule

### sv/neighbour_table_with_expiry_core.sv
// Top level of the neighbour table with expiry: controller plus datapath.
//
//  channel   direction  handshake               payload
//  input     in         in_valid / in_stall     cmd, node, pos_*, vel_*, sequence_req, now
//  result    out        out_valid / out_stall   action, slot, evicted_node, expired_mask
//  config    in         cfg_we                  cfg_wdata (timeout)
//
// One beat passes through IDLE to accept it, SCAN reading the table RAM one slot per cycle,
// DRAIN to evaluate the last slot read and FIN to commit; no new beat is taken until commit.
// The slot scan goes through the single RAM read port.
// Reset clears every valid mark at once and loads the timeout with 3000; the table RAM is
// never cleared. A result waiting under out_stall does not block acceptance of the next
// beat, but that beat holds at commit until the result register has been taken.
module neighbour_table_with_expiry_core #(
	parameter int ENTRIES = nte_pkg::ENTRIES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [nte_pkg::TIME_W-1:0]         cfg_wdata,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               cmd,
	input  logic [nte_pkg::NODE_W-1:0]         node,
	input  logic [nte_pkg::POS_W-1:0]          pos_x,
	input  logic [nte_pkg::POS_W-1:0]          pos_y,
	input  logic [nte_pkg::POS_W-1:0]          pos_z,
	input  logic signed [nte_pkg::VEL_W-1:0]   vel_x,
	input  logic signed [nte_pkg::VEL_W-1:0]   vel_y,
	input  logic signed [nte_pkg::VEL_W-1:0]   vel_z,
	input  logic [nte_pkg::SEQ_W-1:0]          sequence_req,
	input  logic [nte_pkg::TIME_W-1:0]         now,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         action,
	output logic [nte_pkg::SLOT_W-1:0]         slot,
	output logic [nte_pkg::NODE_W-1:0]         evicted_node,
	output logic [nte_pkg::MASK_W-1:0]         expired_mask
);

	nte_pkg::ctl_cmd_t   ctl;
	nte_pkg::dp_status_t status;

	nte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.ctl       (ctl)
	);

	nte_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.cmd          (cmd),
		.node         (node),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.vel_x        (vel_x),
		.vel_y        (vel_y),
		.vel_z        (vel_z),
		.sequence_req (sequence_req),
		.now          (now),
		.action       (action),
		.slot         (slot),
		.evicted_node (evicted_node),
		.expired_mask (expired_mask)
	);

endmodule

### tb/nte_checker.sv
// Checker for the neighbour table: predicts every result beat and compares it with the block.
module nte_checker
	import nte_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [TIME_W-1:0]         cfg_wdata,
	input  logic                      in_valid,
	input  logic                      in_stall,
	input  logic                      cmd,
	input  logic [NODE_W-1:0]         node,
	input  logic [TIME_W-1:0]         now,
	input  logic                      out_valid,
	input  logic                      out_stall,
	input  logic [1:0]                action,
	input  logic [SLOT_W-1:0]         slot,
	input  logic [NODE_W-1:0]         evicted_node,
	input  logic [MASK_W-1:0]         expired_mask,
	output int                        mismatches,
	output int                        outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		action_t            act;
		logic [SLOT_W-1:0]  slot;
		logic [NODE_W-1:0]  evicted;
		logic [MASK_W-1:0]  mask;
	} table_result_t;

	logic [TIME_W-1:0] timeout_copy;
	logic              live [ENTRIES];
	logic [NODE_W-1:0] owner [ENTRIES];
	logic [TIME_W-1:0] heard [ENTRIES];
	table_result_t     awaited_q [$];

	always @(posedge clk or negedge arst_n) begin : predict_and_compare
		table_result_t want;
		int hit;
		int spare;
		int eldest;
		int target;
		if (!arst_n) begin
			timeout_copy = TIMEOUT_RESET;
			for (int i = 0; i < ENTRIES; i++)
				live[i] = 1'b0;
			awaited_q.delete();
			mismatches = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we)
				timeout_copy = cfg_wdata;

			if (in_valid && !in_stall) begin
				want = '0;
				if (cmd == CMD_EXPIRE) begin
					want.act = ACT_EXPIRED;
					// The age wraps at 32 bits, so a heard time "in the future" looks very old.
					for (int i = 0; i < ENTRIES; i++) begin
						if (live[i] && TIME_W'(now - heard[i]) > timeout_copy) begin
							live[i] = 1'b0;
							if (i < MASK_W)
								want.mask[i] = 1'b1;
						end
					end
				end else begin
					hit = -1;
					spare = -1;
					eldest = -1;
					for (int i = 0; i < ENTRIES; i++) begin
						if (live[i]) begin
							if (hit < 0 && owner[i] == node)
								hit = i;
							if (eldest < 0 || heard[i] < heard[eldest])
								eldest = i;
						end else if (spare < 0) begin
							spare = i;
						end
					end
					if (hit >= 0) begin
						target = hit;
						want.act = ACT_UPDATED;
					end else if (spare >= 0) begin
						target = spare;
						want.act = ACT_INSERTED;
					end else begin
						target = eldest;
						want.act = ACT_REPLACED;
						want.evicted = owner[eldest];
					end
					owner[target] = node;
					heard[target] = now;
					live[target] = 1'b1;
					want.slot = SLOT_W'(target);
				end
				awaited_q.push_back(want);
			end

			if (out_valid && !out_stall) begin
				if (awaited_q.size() == 0) begin
					$error("result beat with nothing awaited: action %0d slot %0d", action, slot);
					mismatches++;
				end else begin
					want = awaited_q.pop_front();
					if (action !== want.act) begin
						$error("action: expected %0d, got %0d", want.act, action);
						mismatches++;
					end
					if (slot !== want.slot) begin
						$error("slot: expected %0d, got %0d", want.slot, slot);
						mismatches++;
					end
					if (evicted_node !== want.evicted) begin
						$error("evicted_node: expected 0x%02h, got 0x%02h", want.evicted,
							evicted_node);
						mismatches++;
					end
					if (expired_mask !== want.mask) begin
						$error("expired_mask: expected 0x%01h, got 0x%01h", want.mask,
							expired_mask);
						mismatches++;
					end
				end
			end

			outstanding <= awaited_q.size();
		end
	end

endmodule

### tb/neighbour_table_with_expiry_core_tb.sv
// Testbench top for the neighbour table with expiry: stimulus, idling and the verdict.
module neighbour_table_with_expiry_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nte_pkg::*;

	localparam int LIMIT       = 1_000_000;
	localparam int SETTLE      = ENTRIES_DEF + 3;
	localparam int PHASES      = 8;
	localparam int PHASE_BEATS = 210;

	typedef struct {
		cmd_t                     cmd;
		logic [NODE_W-1:0]        node;
		logic [POS_W-1:0]         px;
		logic [POS_W-1:0]         py;
		logic [POS_W-1:0]         pz;
		logic signed [VEL_W-1:0]  vx;
		logic signed [VEL_W-1:0]  vy;
		logic signed [VEL_W-1:0]  vz;
		logic [SEQ_W-1:0]         seq;
		logic [TIME_W-1:0]        now;
	} report_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [TIME_W-1:0]        cfg_wdata = '0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic                     cmd = CMD_UPDATE;
	logic [NODE_W-1:0]        node = '0;
	logic [POS_W-1:0]         pos_x = '0;
	logic [POS_W-1:0]         pos_y = '0;
	logic [POS_W-1:0]         pos_z = '0;
	logic signed [VEL_W-1:0]  vel_x = '0;
	logic signed [VEL_W-1:0]  vel_y = '0;
	logic signed [VEL_W-1:0]  vel_z = '0;
	logic [SEQ_W-1:0]         sequence_req = '0;
	logic [TIME_W-1:0]        now = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [1:0]               action;
	logic [SLOT_W-1:0]        slot;
	logic [NODE_W-1:0]        evicted_node;
	logic [MASK_W-1:0]        expired_mask;

	int                mismatches;
	int                outstanding;
	int                cycle_count = 0;
	bit                tx_idle = 1'b0;
	bit                rx_idle = 1'b0;
	int                hold_request = 0;
	logic [TIME_W-1:0] clock_ms = '0;
	logic [TIME_W-1:0] timeout_plan [PHASES] = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd2500,
		32'd0, 32'd500, 32'd3000, 32'h8000_0000};
	report_t           report_q [$];

	neighbour_table_with_expiry_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.node         (node),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.vel_x        (vel_x),
		.vel_y        (vel_y),
		.vel_z        (vel_z),
		.sequence_req (sequence_req),
		.now          (now),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.action       (action),
		.slot         (slot),
		.evicted_node (evicted_node),
		.expired_mask (expired_mask)
	);

	nte_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.cmd          (cmd),
		.node         (node),
		.now          (now),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.action       (action),
		.slot         (slot),
		.evicted_node (evicted_node),
		.expired_mask (expired_mask),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT) begin
			$display("FAIL neighbour_table_with_expiry_core");
			$finish;
		end
	end

	// Result side: a random stall before each beat while rx_idle is set, or a long hold-off when one is asked for.
	initial begin : result_taker
		int k;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				k = hold_request;
				hold_request = 0;
			end else begin
				k = rx_idle ? $urandom_range(0, 17) : 0;
			end
			if (k > 0) begin
				out_stall <= 1'b1;
				repeat (k) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	task automatic queue_fixed(input cmd_t c, input logic [NODE_W-1:0] id,
		input logic [POS_W-1:0] px, input logic [POS_W-1:0] py, input logic [POS_W-1:0] pz,
		input logic [VEL_W-1:0] vx, input logic [VEL_W-1:0] vy, input logic [VEL_W-1:0] vz,
		input logic [SEQ_W-1:0] seq, input logic [TIME_W-1:0] t);
		report_t r;
		r.cmd = c;
		r.node = id;
		r.px = px;
		r.py = py;
		r.pz = pz;
		r.vx = vx;
		r.vy = vy;
		r.vz = vz;
		r.seq = seq;
		r.now = t;
		report_q.push_back(r);
	endtask

	// Mostly a small pool of node ids so that matches and replacements are common.
	task automatic queue_random();
		int r;
		cmd_t c;
		logic [NODE_W-1:0] id;
		r = $urandom_range(0, 99);
		if (r < 15)
			clock_ms = clock_ms;
		else if (r < 85)
			clock_ms = clock_ms + $urandom_range(1, 1500);
		else if (r < 95)
			clock_ms = clock_ms + $urandom_range(1500, 6000);
		else
			clock_ms = $urandom;
		c = ($urandom_range(0, 4) == 0) ? CMD_EXPIRE : CMD_UPDATE;
		id = ($urandom_range(0, 9) < 7) ? NODE_W'($urandom_range(0, 5))
			: NODE_W'($urandom_range(0, 255));
		queue_fixed(c, id, POS_W'($urandom_range(0, 20'hFFFFF)),
			POS_W'($urandom_range(0, 20'hFFFFF)), POS_W'($urandom_range(0, 20'hFFFFF)),
			VEL_W'($urandom_range(0, 16'hFFFF)), VEL_W'($urandom_range(0, 16'hFFFF)),
			VEL_W'($urandom_range(0, 16'hFFFF)), SEQ_W'($urandom_range(0, 16'hFFFF)),
			clock_ms);
	endtask

	// Offers every queued beat; valid stays high between back-to-back beats.
	task automatic drain_reports();
		report_t r;
		int gap;
		while (report_q.size() > 0) begin
			r = report_q.pop_front();
			gap = tx_idle ? $urandom_range(0, 17) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			cmd <= r.cmd;
			node <= r.node;
			pos_x <= r.px;
			pos_y <= r.py;
			pos_z <= r.pz;
			vel_x <= r.vx;
			vel_y <= r.vy;
			vel_z <= r.vz;
			sequence_req <= r.seq;
			now <= r.now;
			in_valid <= 1'b1;
			do @(posedge clk); while (in_stall);
		end
		in_valid <= 1'b0;
	endtask

	task automatic wait_quiet();
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_timeout(input logic [TIME_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		timeout_plan[4] = $urandom;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed beats under the reset timeout of 3000 ms.
		queue_fixed(CMD_EXPIRE, 8'h00, '0, '0, '0, '0, '0, '0, '0, 32'd0);
		queue_fixed(CMD_UPDATE, 8'h00, '0, '0, '0, '0, '0, '0, '0, 32'd0);
		queue_fixed(CMD_UPDATE, 8'hFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 16'h7FFF, 16'h7FFF,
			16'h7FFF, 16'hFFFF, 32'd100);
		queue_fixed(CMD_UPDATE, 8'h00, 20'h12345, 20'hABCDE, 20'h00001, 16'h8000, 16'h8000,
			16'h8000, 16'h0001, 32'd200);
		queue_fixed(CMD_UPDATE, 8'h10, 20'h55555, 20'hAAAAA, 20'h0F0F0, 16'hFFFF, 16'h0000,
			16'h1234, 16'h5555, 32'd200);
		queue_fixed(CMD_UPDATE, 8'h11, 20'hAAAAA, 20'h55555, 20'hF0F0F, 16'h0001, 16'hFFFF,
			16'hEDCB, 16'hAAAA, 32'd50);
		// The table is full now: the oldest heard time goes, then ties fall to the lower slot.
		queue_fixed(CMD_UPDATE, 8'h20, '0, '0, '0, '0, '0, '0, 16'd7, 32'd300);
		queue_fixed(CMD_UPDATE, 8'h21, '0, '0, '0, '0, '0, '0, 16'd8, 32'd300);
		queue_fixed(CMD_UPDATE, 8'h22, '0, '0, '0, '0, '0, '0, 16'd9, 32'd400);
		// An age equal to the timeout survives; one millisecond more expires it.
		queue_fixed(CMD_EXPIRE, 8'hFF, 20'hFFFFF, '0, 20'hFFFFF, 16'h7FFF, '0, 16'h8000,
			16'hFFFF, 32'd3200);
		queue_fixed(CMD_EXPIRE, 8'h00, '0, '0, '0, '0, '0, '0, '0, 32'd3201);
		queue_fixed(CMD_UPDATE, 8'h23, '0, '0, '0, '0, '0, '0, '0, 32'd3300);
		// Across the wrap of the millisecond counter.
		queue_fixed(CMD_UPDATE, 8'h24, '0, '0, '0, '0, '0, '0, '0, 32'hFFFF_FF00);
		queue_fixed(CMD_EXPIRE, 8'h00, '0, '0, '0, '0, '0, '0, '0, 32'h0000_0100);
		queue_fixed(CMD_UPDATE, 8'h24, 20'h00001, '0, '0, 16'h0001, '0, '0, 16'd1,
			32'h0000_0100);
		queue_fixed(CMD_EXPIRE, 8'h7F, '0, '0, '0, '0, '0, '0, '0, 32'hFFFF_FFFF);
		drain_reports();
		clock_ms = 32'h0000_0100;

		for (int p = 0; p < PHASES; p++) begin
			wait_quiet();
			write_timeout(timeout_plan[p]);
			tx_idle = (p != 0) && ($urandom_range(0, 3) != 0);
			rx_idle = (p != 0) && ($urandom_range(0, 3) != 0);
			if (p == 3)
				clock_ms = 32'hFFFF_F000;
			repeat (PHASE_BEATS) queue_random();
			drain_reports();
			if (p == 2) begin
				// Hold the result side off while beats keep coming, so the input stalls.
				wait_quiet();
				tx_idle = 1'b0;
				hold_request = 400;
				repeat (50) queue_random();
				drain_reports();
			end
		end
		wait_quiet();

		if (mismatches == 0)
			$display("PASS neighbour_table_with_expiry_core");
		else
			$display("FAIL neighbour_table_with_expiry_core");
		$finish;
	end

endmodule
